// ----- hdl/array_linked_list_manager_top_macros.svh -----
// Assertion macros shared by the checker of the linked list manager.
`ifndef ARRAY_LINKED_LIST_MANAGER_TOP_MACROS_SVH
`define ARRAY_LINKED_LIST_MANAGER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ALM_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ALM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/alm_pkg.sv -----
// Shared types and constants of the linked list manager.
`timescale 1ns / 1ps
package alm_pkg;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned WordW   = 32;

  localparam logic [CmdW-1:0] CmdAppend      = 3'd0;
  localparam logic [CmdW-1:0] CmdRemoveMatch = 3'd1;
  localparam logic [CmdW-1:0] CmdRemoveTail  = 3'd2;
  localparam logic [CmdW-1:0] CmdReadHead    = 3'd3;
  localparam logic [CmdW-1:0] CmdFind        = 3'd4;

  localparam logic [StatusW-1:0] StOk   = 2'd0;
  localparam logic [StatusW-1:0] StFull = 2'd1;
  localparam logic [StatusW-1:0] StNone = 2'd2;

  typedef enum logic [1:0] {RdHead, RdTail, RdFree, RdNext} rd_sel_e;

  typedef enum logic [2:0] {
    UpdNone,
    UpdAppLink,
    UpdAppCommit,
    UpdUnlinkNbr,
    UpdUnlinkFree
  } upd_e;

  typedef enum logic [1:0] {DselZero, DselValue, DselRam} dsel_e;

  typedef struct packed {
    logic                capture;
    logic                rd_en;
    rd_sel_e             rd_sel;
    upd_e                upd;
    logic                res_en;
    logic [StatusW-1:0]  res_status;
    dsel_e               res_dsel;
    logic                step_clr;
    logic                step_inc;
    logic                publish;
  } alm_ctl_t;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            head_null;
    logic            free_null;
    logic            match;
    logic            next_null;
    logic            step_last;
    logic            out_busy;
  } alm_sts_t;

endpackage

// ----- hdl/array_linked_list_manager_top.sv -----
// Top level of the array-backed doubly linked list manager with free stack.
//
//   channel   dir   handshake                 payload
//   --------  ----  ------------------------  ------------------------------------
//   command   in    in_valid_i / in_ready_o   command_i, value_i, key_i
//   result    out   out_valid_o / out_ready_i status_o, data_out_o, is_empty_o,
//                                             is_full_o
//
// One item at a time. Errors (full, empty, unknown command) go from decode to the result;
// append links the free entry, then commits; read head reads the head; remove tail reads,
// unlinks, then frees the tail. Find and remove matching walk from the head, one entry per
// cycle, 1 to DEPTH entries; a remove hit then unlinks and frees. Ready returns in the same
// cycle as the result turns valid; a stalled result holds the final step. Reset clears the
// pointers and out_valid only; a high-water mark replaces the free stack's reset chain.
`timescale 1ns / 1ps
module array_linked_list_manager_top #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [alm_pkg::CmdW-1:0]    command_i,
  input  logic [alm_pkg::WordW-1:0]   value_i,
  input  logic [alm_pkg::WordW-1:0]   key_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [alm_pkg::StatusW-1:0] status_o,
  output logic [alm_pkg::WordW-1:0]   data_out_o,
  output logic                        is_empty_o,
  output logic                        is_full_o
);
  import alm_pkg::*;

  // Commands from the sequencer and the flags it branches on.
  alm_ctl_t ctl;
  alm_sts_t sts;

  // Sequencer: decode, walk the list, drive the RAM updates step by step.
  alm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Datapath: link and value RAMs, head/tail/free pointers, result register.
  alm_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .command_i   (command_i),
    .value_i     (value_i),
    .key_i       (key_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .data_out_o  (data_out_o),
    .is_empty_o  (is_empty_o),
    .is_full_o   (is_full_o)
  );

endmodule

// ----- hdl/alm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module alm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/alm_ctrl.sv -----
// Command sequencer of the linked list manager.
`timescale 1ns / 1ps
module alm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  alm_pkg::alm_sts_t sts_i,
  output alm_pkg::alm_ctl_t ctl_o
);
  import alm_pkg::*;

  localparam logic [2:0] SIdle       = 3'd0;
  localparam logic [2:0] SDecode     = 3'd1;
  localparam logic [2:0] SAppCommit  = 3'd2;
  localparam logic [2:0] SReadHead   = 3'd3;
  localparam logic [2:0] SSearch     = 3'd4;
  localparam logic [2:0] SUnlinkNbr  = 3'd5;
  localparam logic [2:0] SUnlinkFree = 3'd6;
  localparam logic [2:0] SDone       = 3'd7;

  logic [2:0] state_q, state_d;
  alm_ctl_t   ctl;

  always_comb begin
    state_d = state_q;
    ctl     = '0;
    case (state_q)
      SIdle: begin
        ctl.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = SDecode;
        end
      end
      SDecode: begin
        case (sts_i.cmd)
          CmdAppend: begin
            if (sts_i.free_null) begin
              ctl.res_en     = 1'b1;
              ctl.res_status = StFull;
              ctl.res_dsel   = DselZero;
              state_d        = SDone;
            end else begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = RdFree;
              ctl.upd    = UpdAppLink;
              state_d    = SAppCommit;
            end
          end
          CmdRemoveMatch, CmdFind: begin
            if (sts_i.head_null) begin
              ctl.res_en     = 1'b1;
              ctl.res_status = StNone;
              state_d        = SDone;
            end else begin
              ctl.rd_en    = 1'b1;
              ctl.rd_sel   = RdHead;
              ctl.step_clr = 1'b1;
              state_d      = SSearch;
            end
          end
          CmdRemoveTail: begin
            if (sts_i.head_null) begin
              ctl.res_en     = 1'b1;
              ctl.res_status = StNone;
              state_d        = SDone;
            end else begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = RdTail;
              state_d    = SUnlinkNbr;
            end
          end
          CmdReadHead: begin
            if (sts_i.head_null) begin
              ctl.res_en     = 1'b1;
              ctl.res_status = StNone;
              state_d        = SDone;
            end else begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = RdHead;
              state_d    = SReadHead;
            end
          end
          default: begin
            ctl.res_en     = 1'b1;
            ctl.res_status = StNone;
            state_d        = SDone;
          end
        endcase
      end
      SAppCommit: begin
        ctl.upd        = UpdAppCommit;
        ctl.res_en     = 1'b1;
        ctl.res_status = StOk;
        ctl.res_dsel   = DselValue;
        state_d        = SDone;
      end
      SReadHead: begin
        ctl.res_en     = 1'b1;
        ctl.res_status = StOk;
        ctl.res_dsel   = DselRam;
        state_d        = SDone;
      end
      SSearch: begin
        if (sts_i.match) begin
          if (sts_i.cmd == CmdFind) begin
            ctl.res_en     = 1'b1;
            ctl.res_status = StOk;
            ctl.res_dsel   = DselRam;
            state_d        = SDone;
          end else begin
            state_d = SUnlinkNbr;
          end
        end else if (sts_i.next_null || sts_i.step_last) begin
          ctl.res_en     = 1'b1;
          ctl.res_status = StNone;
          state_d        = SDone;
        end else begin
          // advance the walk to the next entry
          ctl.rd_en    = 1'b1;
          ctl.rd_sel   = RdNext;
          ctl.step_inc = 1'b1;
        end
      end
      SUnlinkNbr: begin
        ctl.upd        = UpdUnlinkNbr;
        ctl.res_en     = 1'b1;
        ctl.res_status = StOk;
        ctl.res_dsel   = DselRam;
        state_d        = SUnlinkFree;
      end
      SUnlinkFree: begin
        ctl.upd = UpdUnlinkFree;
        state_d = SDone;
      end
      SDone: begin
        if (!sts_i.out_busy) begin
          ctl.publish = 1'b1;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == SIdle);
  assign ctl_o      = ctl;

endmodule

// ----- hdl/alm_dp.sv -----
// Datapath of the linked list manager: link and value RAMs, list pointers, result.
`timescale 1ns / 1ps
module alm_dp #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [alm_pkg::CmdW-1:0]      command_i,
  input  logic [alm_pkg::WordW-1:0]     value_i,
  input  logic [alm_pkg::WordW-1:0]     key_i,
  input  alm_pkg::alm_ctl_t             ctl_i,
  output alm_pkg::alm_sts_t             sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [alm_pkg::StatusW-1:0]   status_o,
  output logic [alm_pkg::WordW-1:0]     data_out_o,
  output logic                          is_empty_o,
  output logic                          is_full_o
);
  import alm_pkg::*;

  localparam int unsigned IdxW   = $clog2(DEPTH);
  localparam int unsigned LinkW  = $clog2(DEPTH + 1);
  localparam int unsigned StoreW = (DATA_WIDTH < WordW) ? DATA_WIDTH : WordW;
  localparam logic [LinkW-1:0] Nil = LinkW'(DEPTH);

  logic [CmdW-1:0]    cmd_q;
  logic [StoreW-1:0]  val_q, key_q;
  logic [LinkW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [LinkW-1:0]   free_q, free_d, hwm_q, hwm_d;
  logic [LinkW-1:0]   cur_q;
  logic               ovr_q;
  logic [IdxW-1:0]    step_q;
  logic [StatusW-1:0] res_status_q;
  logic [StoreW-1:0]  res_data_q, res_data;
  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [WordW-1:0]   out_data_q;
  logic               out_empty_q, out_full_q;

  logic [LinkW-1:0]   rd_addr, next_eff;
  logic [LinkW-1:0]   nxt_rdata, prv_rdata;
  logic [StoreW-1:0]  val_rdata;
  logic               nxt_we, prv_we, val_we;
  logic [IdxW-1:0]    nxt_waddr, prv_waddr, val_waddr;
  logic [LinkW-1:0]   nxt_wdata, prv_wdata;
  logic               head_null;

  assign head_null = (head_q == Nil);

  // Entries at or above the high-water mark were never allocated; their
  // next link is taken as the reset chain value, index plus one, not read from the RAM.
  assign next_eff = ovr_q ? LinkW'(cur_q + LinkW'(1)) : nxt_rdata;

  always_comb begin
    case (ctl_i.rd_sel)
      RdHead:  rd_addr = head_q;
      RdTail:  rd_addr = tail_q;
      RdFree:  rd_addr = free_q;
      RdNext:  rd_addr = next_eff;
      default: rd_addr = head_q;
    endcase
  end

  always_comb begin
    nxt_we    = 1'b0;
    nxt_waddr = cur_q[IdxW-1:0];
    nxt_wdata = Nil;
    prv_we    = 1'b0;
    prv_waddr = cur_q[IdxW-1:0];
    prv_wdata = Nil;
    val_we    = 1'b0;
    val_waddr = free_q[IdxW-1:0];
    head_d    = head_q;
    tail_d    = tail_q;
    free_d    = free_q;
    hwm_d     = hwm_q;
    case (ctl_i.upd)
      UpdAppLink: begin
        val_we    = 1'b1;
        prv_we    = 1'b1;
        prv_waddr = free_q[IdxW-1:0];
        prv_wdata = head_null ? Nil : tail_q;
        nxt_we    = !head_null;
        nxt_waddr = tail_q[IdxW-1:0];
        nxt_wdata = free_q;
      end
      UpdAppCommit: begin
        nxt_we = 1'b1;
        free_d = next_eff;
        if (ovr_q) begin
          hwm_d = LinkW'(hwm_q + LinkW'(1));
        end
        if (head_null) begin
          head_d = cur_q;
        end
        tail_d = cur_q;
      end
      UpdUnlinkNbr: begin
        nxt_we    = (prv_rdata != Nil);
        nxt_waddr = prv_rdata[IdxW-1:0];
        nxt_wdata = next_eff;
        prv_we    = (next_eff != Nil);
        prv_waddr = next_eff[IdxW-1:0];
        prv_wdata = prv_rdata;
        if (prv_rdata == Nil) begin
          head_d = next_eff;
        end
        if (next_eff == Nil) begin
          tail_d = prv_rdata;
        end
      end
      UpdUnlinkFree: begin
        nxt_we    = 1'b1;
        nxt_wdata = free_q;
        free_d    = cur_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (ctl_i.res_dsel)
      DselValue: res_data = val_q;
      DselRam:   res_data = val_rdata;
      default:   res_data = '0;
    endcase
  end

  alm_ram #(.WIDTH(LinkW), .DEPTH(DEPTH)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .re_i    (ctl_i.rd_en),
    .raddr_i (rd_addr[IdxW-1:0]),
    .rdata_o (nxt_rdata)
  );

  alm_ram #(.WIDTH(LinkW), .DEPTH(DEPTH)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .re_i    (ctl_i.rd_en),
    .raddr_i (rd_addr[IdxW-1:0]),
    .rdata_o (prv_rdata)
  );

  alm_ram #(.WIDTH(StoreW), .DEPTH(DEPTH)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_q),
    .re_i    (ctl_i.rd_en),
    .raddr_i (rd_addr[IdxW-1:0]),
    .rdata_o (val_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= Nil;
      tail_q      <= Nil;
      free_q      <= '0;
      hwm_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      free_q <= free_d;
      hwm_q  <= hwm_d;
      if (ctl_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q <= command_i;
      val_q <= value_i[StoreW-1:0];
      key_q <= key_i[StoreW-1:0];
    end
    if (ctl_i.rd_en) begin
      cur_q <= rd_addr;
      ovr_q <= (rd_addr >= hwm_q);
    end
    if (ctl_i.step_clr) begin
      step_q <= '0;
    end else if (ctl_i.step_inc) begin
      step_q <= IdxW'(step_q + IdxW'(1));
    end
    if (ctl_i.res_en) begin
      res_status_q <= ctl_i.res_status;
      res_data_q   <= res_data;
    end
    if (ctl_i.publish) begin
      out_status_q <= res_status_q;
      out_data_q   <= WordW'(res_data_q);
      out_empty_q  <= head_null;
      out_full_q   <= (free_q == Nil);
    end
  end

  assign sts_o.cmd       = cmd_q;
  assign sts_o.head_null = head_null;
  assign sts_o.free_null = (free_q == Nil);
  assign sts_o.match     = (val_rdata == key_q);
  assign sts_o.next_null = (next_eff == Nil);
  assign sts_o.step_last = (step_q == IdxW'(DEPTH - 1));
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign data_out_o  = out_data_q;
  assign is_empty_o  = out_empty_q;
  assign is_full_o   = out_full_q;

endmodule

// ----- hdl/alm_checker.sv -----
// Port-level assertions of the linked list manager and their bind.
`timescale 1ns / 1ps
`include "array_linked_list_manager_top_macros.svh"
module alm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [alm_pkg::StatusW-1:0] status_o,
  input logic [alm_pkg::WordW-1:0]   data_out_o,
  input logic                        is_full_o
);
  import alm_pkg::*;

  `ALM_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(data_out_o), "result changed while stalled")
  `ALM_ASSERT_SAME(a_err_zero, clk_i, rst_ni, out_valid_o && (status_o != StOk), data_out_o == '0, "nonzero data on error status")
  `ALM_ASSERT_SAME(a_full_flag, clk_i, rst_ni, out_valid_o && (status_o == StFull), is_full_o, "full status without full flag")
  `ALM_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "ready right after accept")

endmodule

bind array_linked_list_manager_top alm_checker u_alm_checker (.*);
